// ----- rtl/esm_pkg.sv -----
// ----------------------------------------------------------------------------
// esm_pkg: shared types and constants of the early stop monitor
// Function codes, register indexes, cause bits and the configuration and
// result bundles passed between the top level and the evaluation core.
// ----------------------------------------------------------------------------
package esm_pkg;

    // Field widths
    localparam int OBJ_W      = 32;
    localparam int FACTOR_W   = 24;
    localparam int STEPS_W    = 13;
    localparam int TRIAL_W    = 12;
    localparam int CAUSE_W    = 7;
    localparam int BEST_OUT_W = 13;

    // Q16.16 extremes, used as infinities
    localparam logic signed [OBJ_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OBJ_W-1:0] Q_MIN = 32'sh8000_0000;

    // Function codes of an input item (code 3 is unused)
    localparam logic [1:0] FUNC_FIRST   = 2'd0;
    localparam logic [1:0] FUNC_REPORT  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_LOWER_BOUND    = 3'd0;
    localparam logic [2:0] CFG_UPPER_BOUND    = 3'd1;
    localparam logic [2:0] CFG_DEGRADE_LIMIT  = 3'd2;
    localparam logic [2:0] CFG_REL_DEGRADE    = 3'd3;
    localparam logic [2:0] CFG_IMPROVE_FLOOR  = 3'd4;
    localparam logic [2:0] CFG_REL_IMPROVE    = 3'd5;
    localparam logic [2:0] CFG_PATIENCE_STEPS = 3'd6;
    localparam logic [2:0] CFG_WARMUP_STEPS   = 3'd7;

    // Cause mask bit positions
    localparam int CAUSE_LOW         = 0;
    localparam int CAUSE_HIGH        = 1;
    localparam int CAUSE_PATIENCE    = 2;
    localparam int CAUSE_DEGRADE     = 3;
    localparam int CAUSE_REL_DEGRADE = 4;
    localparam int CAUSE_IMPROVE     = 5;
    localparam int CAUSE_REL_IMPROVE = 6;

    typedef struct packed {
        logic signed [OBJ_W-1:0]    lower_bound;
        logic signed [OBJ_W-1:0]    upper_bound;
        logic signed [OBJ_W-1:0]    degradation_limit;
        logic signed [FACTOR_W-1:0] relative_degradation;
        logic signed [OBJ_W-1:0]    improvement_floor;
        logic signed [FACTOR_W-1:0] relative_improvement;
        logic [STEPS_W-1:0]         patience_steps;
        logic [STEPS_W-1:0]         warmup_steps;
    } cfg_t;

    typedef struct packed {
        logic                   trial_valid;
        logic [TRIAL_W-1:0]     trial_index;
        logic                   stopped;
        logic [CAUSE_W-1:0]     cause_mask;
        logic [BEST_OUT_W-1:0]  best_trial;
    } res_t;

endpackage

// ----- rtl/esm_core.sv -----
// ----------------------------------------------------------------------------
// esm_core: monitor state and single-pass evaluation of one item
// Holds trial count, previous and best objective, best step and stop flag,
// and forms the result of the item presented this cycle from that state.
// ----------------------------------------------------------------------------
module esm_core #(
    parameter int NUM_TRIALS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [1:0]                 func,
    input  logic signed [31:0]         objective,
    input  esm_pkg::cfg_t              cfg,
    output esm_pkg::res_t              res
);
    import esm_pkg::*;

    localparam int STEP_W = $clog2(NUM_TRIALS + 1);
    // wide enough for step minus best step and for the 13-bit step registers
    localparam int CW     = (STEP_W + 2 > STEPS_W + 2) ? STEP_W + 2 : STEPS_W + 2;
    localparam int PROD_W = (FACTOR_W - 1) + OBJ_W;
    localparam int CMP_W  = PROD_W + 2;

    logic [STEP_W-1:0]        trials_reg,   trials_next;
    logic signed [OBJ_W-1:0]  prev_reg,     prev_next;
    logic signed [OBJ_W-1:0]  best_reg,     best_next;
    logic signed [STEP_W:0]   best_idx_reg, best_idx_next;
    logic                     stop_reg,     stop_next;

    logic                     is_report;
    logic                     is_restart;
    logic                     active;
    logic                     warm;
    logic                     better;
    logic signed [STEP_W:0]   best_idx_new;
    logic signed [OBJ_W:0]    obj_x;
    logic signed [OBJ_W:0]    deg_diff;
    logic signed [OBJ_W:0]    deg_eff;
    logic signed [OBJ_W:0]    imp_diff;
    logic [OBJ_W-1:0]         best_mag;
    logic [OBJ_W-1:0]         prev_mag;
    logic [PROD_W-1:0]        deg_prod;
    logic [PROD_W-1:0]        imp_prod;
    logic signed [CMP_W-1:0]  deg_lhs;
    logic signed [CMP_W-1:0]  imp_lhs;
    logic signed [CW-1:0]     pat_diff;
    logic                     best_inf_new;
    logic                     prev_inf;
    logic [CAUSE_W-1:0]       cause_raw;
    logic                     stop_hit;
    logic                     stop_after;
    logic                     issue;

    // Decode the item
    assign is_report  = (func == FUNC_REPORT);
    assign is_restart = (func == FUNC_RESTART);
    assign active     = ((func == FUNC_FIRST) || is_report) && !stop_reg;

    // Warmup gate and best tracking
    assign warm         = CW'(trials_reg) >= CW'(cfg.warmup_steps);
    assign better       = (objective < best_reg) && warm;
    assign best_idx_new = better ? $signed({1'b0, trials_reg}) : best_idx_reg;
    assign best_inf_new = !better && (best_reg == Q_MAX);
    assign prev_inf     = (prev_reg == Q_MAX);

    // Exact differences; degradation is zero when the best moves to this item
    assign obj_x    = {objective[OBJ_W-1], objective};
    assign deg_diff = obj_x - $signed({best_reg[OBJ_W-1], best_reg});
    assign deg_eff  = better ? '0 : deg_diff;
    assign imp_diff = $signed({prev_reg[OBJ_W-1], prev_reg}) - obj_x;

    // Magnitudes and relative limits; a negative factor disables the test
    assign best_mag = best_reg[OBJ_W-1] ? (~best_reg + 32'd1) : best_reg;
    assign prev_mag = prev_reg[OBJ_W-1] ? (~prev_reg + 32'd1) : prev_reg;
    assign deg_prod = PROD_W'(cfg.relative_degradation[FACTOR_W-2:0]) * PROD_W'(best_mag);
    assign imp_prod = PROD_W'(cfg.relative_improvement[FACTOR_W-2:0]) * PROD_W'(prev_mag);
    assign deg_lhs  = {{(CMP_W-OBJ_W-17){deg_eff[OBJ_W]}}, deg_eff, 16'b0};
    assign imp_lhs  = {{(CMP_W-OBJ_W-17){imp_diff[OBJ_W]}}, imp_diff, 16'b0};

    // Steps since the best
    assign pat_diff = $signed(CW'(trials_reg)) - CW'(best_idx_new);

    // Stop tests
    always_comb
    begin
        cause_raw = '0;
        cause_raw[CAUSE_LOW]  = objective < cfg.lower_bound;
        cause_raw[CAUSE_HIGH] = objective > cfg.upper_bound;
        cause_raw[CAUSE_PATIENCE] = pat_diff >= $signed(CW'(cfg.patience_steps));
        cause_raw[CAUSE_DEGRADE] = !best_inf_new && (cfg.degradation_limit != Q_MAX)
            && (deg_eff > $signed({cfg.degradation_limit[OBJ_W-1], cfg.degradation_limit}));
        cause_raw[CAUSE_REL_DEGRADE] = !best_inf_new && !cfg.relative_degradation[FACTOR_W-1]
            && (deg_lhs > $signed({2'b00, deg_prod}));
        cause_raw[CAUSE_IMPROVE] = !prev_inf && (cfg.improvement_floor != Q_MIN)
            && (imp_diff < $signed({cfg.improvement_floor[OBJ_W-1], cfg.improvement_floor}));
        cause_raw[CAUSE_REL_IMPROVE] = !prev_inf && !cfg.relative_improvement[FACTOR_W-1]
            && (imp_lhs < $signed({2'b00, imp_prod}));
    end

    assign stop_hit   = warm && (cause_raw != '0);
    assign stop_after = (active && is_report) ? stop_hit : stop_reg;
    assign issue      = active && !stop_after && (CW'(trials_reg) < CW'(NUM_TRIALS));

    // Result of the item
    always_comb
    begin
        res.trial_valid = issue;
        res.trial_index = issue ? TRIAL_W'(trials_reg) : '0;
        res.stopped     = is_restart ? 1'b0 : stop_after;
        res.cause_mask  = (active && is_report && stop_hit) ? cause_raw : '0;
        if (is_restart)
        begin
            res.best_trial = '1;
        end
        else if (active && is_report)
        begin
            res.best_trial = BEST_OUT_W'(best_idx_new);
        end
        else
        begin
            res.best_trial = BEST_OUT_W'(best_idx_reg);
        end
    end

    // Next state
    always_comb
    begin
        trials_next   = trials_reg;
        prev_next     = prev_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        stop_next     = stop_reg;
        if (fire)
        begin
            if (is_restart)
            begin
                trials_next   = '0;
                prev_next     = Q_MAX;
                best_next     = Q_MAX;
                best_idx_next = '1;
                stop_next     = 1'b0;
            end
            else
            begin
                if (active && is_report)
                begin
                    prev_next     = objective;
                    best_idx_next = best_idx_new;
                    stop_next     = stop_hit;
                    if (better)
                    begin
                        best_next = objective;
                    end
                end
                if (issue)
                begin
                    trials_next = trials_reg + STEP_W'(1);
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trials_reg   <= '0;
            prev_reg     <= Q_MAX;
            best_reg     <= Q_MAX;
            best_idx_reg <= '1;
            stop_reg     <= 1'b0;
        end
        else
        begin
            trials_reg   <= trials_next;
            prev_reg     <= prev_next;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
            stop_reg     <= stop_next;
        end
    end

`ifndef SYNTHESIS
    // Only a restart clears the stop flag
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg && !(fire && is_restart) |=> stop_reg)
        else $error("stop flag cleared without a restart");

    // The best step never lies ahead of the trials issued
    a_best_behind: assert property (@(posedge clk) disable iff (!rst_n)
        best_idx_reg <= $signed({1'b0, trials_reg}))
        else $error("best step beyond trial count");

    // Trial count stays within the trial range
    a_trials_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(trials_reg) <= CW'(NUM_TRIALS))
        else $error("trial count beyond range");

    // A restart returns the monitor to its reset state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_restart |=> (trials_reg == '0) && !stop_reg && (best_idx_reg == '1)
            && (best_reg == Q_MAX) && (prev_reg == Q_MAX))
        else $error("restart left state behind");
`endif

endmodule

// ----- rtl/early_stop_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// early_stop_monitor_unit: early stopping with patience over objectives
// Usage:
//   s_* carries request items: s_tuser[1:0] func (first, report, restart),
//   s_tdata[31:0] objective in signed Q16.16.
//   m_* carries one result item per request: m_tuser is trial_valid, m_tdata
//   holds trial index, stop flag, cause mask and best step.
//   cfg_wen/cfg_index/cfg_data write the eight limit registers; write only
//   while no item is in flight.
// Path: an accepted item waits in the input register, then after one pass of
//   compare and multiply its result is loaded into the result register.
// Throughput: one item per cycle unless m_tready stalls; the monitor state is
//   updated in the same pass that forms the result, so the next item sees it at once.
// Stall: while m_tready is low the result register holds; one more item is
//   taken into the input register and then s_tready drops.
// Reset: rst_n clears both stages, restores register defaults and puts the
//   monitor in its restart state (no best, trial count zero, not stopped).
// ----------------------------------------------------------------------------
module early_stop_monitor_unit #(
    parameter int NUM_TRIALS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] objective
    input  logic [1:0]  s_tuser,    // [1:0] func
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [11:0] trial_index, [12] stopped,
                                    // [19:13] cause_mask, [32:20] best step
    output logic        m_tuser,    // [0] trial_valid
    // configuration writes
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import esm_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [1:0]         in_func_reg;
    logic signed [31:0] in_obj_reg;
    logic               out_valid_reg;
    res_t               out_res_reg;
    res_t               core_res;
    logic               advance;

    // Move an item into the result register when it is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower_bound          <= Q_MIN;
            cfg_reg.upper_bound          <= Q_MAX;
            cfg_reg.degradation_limit    <= Q_MAX;
            cfg_reg.relative_degradation <= -24'sd65536;
            cfg_reg.improvement_floor    <= Q_MIN;
            cfg_reg.relative_improvement <= -24'sd65536;
            cfg_reg.patience_steps       <= 13'd100;
            cfg_reg.warmup_steps         <= 13'd0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_LOWER_BOUND:    cfg_reg.lower_bound          <= cfg_data;
                CFG_UPPER_BOUND:    cfg_reg.upper_bound          <= cfg_data;
                CFG_DEGRADE_LIMIT:  cfg_reg.degradation_limit    <= cfg_data;
                CFG_REL_DEGRADE:    cfg_reg.relative_degradation <= cfg_data[FACTOR_W-1:0];
                CFG_IMPROVE_FLOOR:  cfg_reg.improvement_floor    <= cfg_data;
                CFG_REL_IMPROVE:    cfg_reg.relative_improvement <= cfg_data[FACTOR_W-1:0];
                CFG_PATIENCE_STEPS: cfg_reg.patience_steps       <= cfg_data[STEPS_W-1:0];
                CFG_WARMUP_STEPS:   cfg_reg.warmup_steps         <= cfg_data[STEPS_W-1:0];
            endcase
        end
    end

    // Input register: take an item whenever the stage is free or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_obj_reg  <= s_tdata;
        end
    end

    esm_core #(
        .NUM_TRIALS (NUM_TRIALS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .func      (in_func_reg),
        .objective (in_obj_reg),
        .cfg       (cfg_reg),
        .res       (core_res)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.trial_valid;
    assign m_tdata  = {7'b0, out_res_reg.best_trial, out_res_reg.cause_mask,
                       out_res_reg.stopped, out_res_reg.trial_index};

`ifndef SYNTHESIS
    // A cause is only reported together with the stop
    a_cause_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.cause_mask != '0) |-> out_res_reg.stopped)
        else $error("cause reported without stop");

    // No trial is handed out by a stopped monitor
    a_trial_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.trial_valid |-> !out_res_reg.stopped
            && (out_res_reg.cause_mask == '0))
        else $error("trial given while stopped");

    // A waiting item stays put while the result side is blocked
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg
            && $stable(in_obj_reg) && $stable(in_func_reg))
        else $error("input item lost during stall");
`endif

endmodule

// ----- bench/tb_early_stop_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// tb_early_stop_monitor_unit: self-checking bench for the early stop monitor
// Feeds first/report/restart items on the request stream and scores every
// result item against a cycle-free predictor of the monitor. A short directed
// plan covers field extremes, every function code, the disabled-test extremes,
// warmup gating, the stopped state and restart. Randomised phases follow,
// each with fresh limit registers, bursty request timing and a receiver that
// stalls in patterns of its own.
// ----------------------------------------------------------------------------
module tb_early_stop_monitor_unit;

    import esm_pkg::*;

    localparam int          TRIALS       = 256;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          PIPE_SLACK   = 4;      // extra wait after the last result before the pipe is taken as empty
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          PLAN_LEN     = 40;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam logic [12:0] NO_BEST      = 13'h1FFF;

    // Q16.16 constants used by the directed plan
    localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [31:0] Q_P1      = 32'h0001_0000;
    localparam logic [31:0] Q_M1      = 32'hFFFF_0000;
    localparam logic [31:0] Q_P2      = 32'h0002_0000;
    localparam logic [31:0] Q_M2      = 32'hFFFE_0000;
    localparam logic [31:0] Q_M3      = 32'hFFFD_0000;
    localparam logic [31:0] Q_P4      = 32'h0004_0000;
    localparam logic [31:0] Q_P4_HALF = 32'h0004_8000;
    localparam logic [31:0] Q_P5      = 32'h0005_0000;

    // Result items that can be read straight off the behaviour
    localparam res_t FRESH_FIRST = '{1'b1, 12'd0, 1'b0, 7'd0, NO_BEST};
    localparam res_t IDLE_RESULT = '{1'b0, 12'd0, 1'b0, 7'd0, NO_BEST};

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [1:0]  func;
        logic [31:0] value;
        logic        fixed;   // use the typed-in result instead of the predictor
        res_t        result;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wen   = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Predictor copy of the limit registers
    longint cfg_low, cfg_high, cfg_deg_limit, cfg_deg_factor;
    longint cfg_imp_floor, cfg_imp_factor, cfg_patience, cfg_warmup;

    // Predictor copy of the monitor state
    longint trial_count, last_obj, best_obj, best_at;
    logic   monitor_halted;

    res_t        pending_results[$];
    plan_row_t   plan [PLAN_LEN];
    logic [31:0] next_cfg [8];
    longint      walk_obj;
    int          burst_left;
    int          stall_left;
    int          stall_mode;
    int          cycle_count;
    int          error_count;
    int          items_sent;
    int          live_items;
    int          results_seen;
    int          stop_count;
    int          exhausted_count;
    int          setting_count;

    early_stop_monitor_unit #(
        .NUM_TRIALS (TRIALS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: switch between always ready, coin flips, long stalls and a periodic pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= (cycle_count % 8 < 5);
        endcase
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_monitor();
        trial_count    = 0;
        last_obj       = longint'(Q_MAX);
        best_obj       = longint'(Q_MAX);
        best_at        = -1;
        monitor_halted = 1'b0;
    endfunction

    function automatic void restore_limits();
        cfg_low        = longint'(Q_MIN);
        cfg_high       = longint'(Q_MAX);
        cfg_deg_limit  = longint'(Q_MAX);
        cfg_deg_factor = -65536;
        cfg_imp_floor  = longint'(Q_MIN);
        cfg_imp_factor = -65536;
        cfg_patience   = 100;
        cfg_warmup     = 0;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            CFG_LOWER_BOUND:    cfg_low        = longint'(signed'(val));
            CFG_UPPER_BOUND:    cfg_high       = longint'(signed'(val));
            CFG_DEGRADE_LIMIT:  cfg_deg_limit  = longint'(signed'(val));
            CFG_REL_DEGRADE:    cfg_deg_factor = longint'(signed'(val[23:0]));
            CFG_IMPROVE_FLOOR:  cfg_imp_floor  = longint'(signed'(val));
            CFG_REL_IMPROVE:    cfg_imp_factor = longint'(signed'(val[23:0]));
            CFG_PATIENCE_STEPS: cfg_patience   = longint'(val[12:0]);
            CFG_WARMUP_STEPS:   cfg_warmup     = longint'(val[12:0]);
            default: ;
        endcase
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the monitor by one item and return the result it gives
    function automatic res_t predict_monitor(input logic [1:0] func,
                                             input logic [31:0] obj_bits);
        res_t       r;
        longint     obj, step, degrade, improve;
        logic       warm, best_open, prev_open;
        logic [6:0] causes;
        r      = '0;
        causes = '0;
        obj    = longint'(signed'(obj_bits));
        if (func == FUNC_RESTART)
            clear_monitor();
        else if (func != FUNC_UNUSED && !monitor_halted)
        begin
            if (func == FUNC_REPORT)
            begin
                step = trial_count;
                warm = (step >= cfg_warmup);
                if (obj < best_obj && warm)
                begin
                    best_obj = obj;
                    best_at  = step;
                end
                // the largest value of best and previous stands for infinity
                best_open = (best_obj != longint'(Q_MAX));
                prev_open = (last_obj != longint'(Q_MAX));
                degrade   = obj - best_obj;
                improve   = last_obj - obj;
                causes[CAUSE_LOW]      = (obj < cfg_low);
                causes[CAUSE_HIGH]     = (obj > cfg_high);
                causes[CAUSE_PATIENCE] = (step - best_at >= cfg_patience);
                causes[CAUSE_DEGRADE]  = best_open && cfg_deg_limit != longint'(Q_MAX)
                                         && degrade > cfg_deg_limit;
                causes[CAUSE_REL_DEGRADE] = best_open && cfg_deg_factor >= 0
                    && degrade * 65536 > cfg_deg_factor * magnitude(best_obj);
                causes[CAUSE_IMPROVE]  = prev_open && cfg_imp_floor != longint'(Q_MIN)
                                         && improve < cfg_imp_floor;
                causes[CAUSE_REL_IMPROVE] = prev_open && cfg_imp_factor >= 0
                    && improve * 65536 < cfg_imp_factor * magnitude(last_obj);
                if (causes != '0 && warm)
                begin
                    monitor_halted = 1'b1;
                    stop_count++;
                end
                else
                    causes = '0;
                last_obj = obj;
            end
            if (!monitor_halted && trial_count < TRIALS)
            begin
                r.trial_valid = 1'b1;
                r.trial_index = trial_count[11:0];
                trial_count++;
            end
            else if (!monitor_halted)
                exhausted_count++;
        end
        r.stopped    = monitor_halted;
        r.cause_mask = causes;
        r.best_trial = best_at[12:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result scoreboard
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item: expected none, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("trial_valid", want.trial_valid, m_tuser);
                check_field("trial_index", want.trial_index, m_tdata[11:0]);
                check_field("stopped", want.stopped, m_tdata[12]);
                check_field("cause_mask", want.cause_mask, m_tdata[19:13]);
                check_field("best_trial", want.best_trial, m_tdata[32:20]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offer one item in bursts with random gaps; record its result on acceptance
    task automatic send_item(input logic [1:0] func, input logic [31:0] obj,
                             input logic fixed, input res_t fixed_result);
        int   gap;
        logic ignored;
        res_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= obj;
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ignored   = (func == FUNC_UNUSED) || (monitor_halted && func != FUNC_RESTART);
        predicted = predict_monitor(func, obj);
        pending_results.push_back(fixed ? fixed_result : predicted);
        items_sent++;
        if (!ignored)
            live_items++;
    endtask

    // Hold the request side until every result is back and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic load_limits();
        for (int i = 0; i < 8; i++)
            put_reg(3'(i), next_cfg[i]);
        cfg_wen <= 1'b0;
        setting_count++;
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return $urandom;
            default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_factor();
        case ($urandom_range(0, 6))
            0:       return {8'h00, 24'h80_0000};
            1:       return {8'h00, 1'b1, 23'($urandom)};
            2:       return 32'h0;
            3:       return {8'h00, 24'h7F_FFFF};
            default: return 32'($urandom_range(0, 32'h0002_0000));
        endcase
    endfunction

    function automatic logic [31:0] rand_steps(input int hi_small);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd4096;
            2:       return 32'($urandom_range(0, 4096));
            default: return 32'($urandom_range(1, hi_small));
        endcase
    endfunction

    // Objectives drift down with noise, with the odd jump and extreme
    function automatic logic [31:0] draw_objective();
        longint nudge;
        case ($urandom_range(0, 31))
            0:  return Q_MIN;
            1:  return Q_MAX;
            2, 3:
            begin
                walk_obj = longint'($signed($urandom));
                return walk_obj[31:0];
            end
            default:
            begin
                nudge    = longint'($urandom_range(0, 32'h0001_8000)) - 64'sd65536;
                walk_obj = walk_obj + nudge;
                if (walk_obj > longint'(Q_MAX))
                    walk_obj = longint'(Q_MAX);
                if (walk_obj < longint'(Q_MIN))
                    walk_obj = longint'(Q_MIN);
                return walk_obj[31:0];
            end
        endcase
    endfunction

    // One run of the monitor: restart, first request, reports, some noise
    task automatic run_sequence(input int reports, input logic noisy);
        int roll;
        walk_obj = longint'($urandom_range(0, 32'h0010_0000)) - 64'sd524288;
        send_item(FUNC_RESTART, $urandom, 1'b0, '0);
        if (!noisy || $urandom_range(0, 9) != 0)
            send_item(FUNC_FIRST, $urandom, 1'b0, '0);
        for (int i = 0; i < reports; i++)
        begin
            roll = noisy ? $urandom_range(0, 59) : 59;
            if (roll < 3)
                send_item(FUNC_UNUSED, $urandom, 1'b0, '0);
            else if (roll < 5)
                send_item(FUNC_FIRST, $urandom, 1'b0, '0);
            else if (roll < 6)
                send_item(FUNC_RESTART, $urandom, 1'b0, '0);
            else
                send_item(FUNC_REPORT, draw_objective(), 1'b0, '0);
            // a few items after a stop, then move on
            if (monitor_halted && $urandom_range(0, 2) == 0)
                break;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        restore_limits();
        clear_monitor();
        plan = '{
            // reset settings: extremes of the objective and every function code
            '{ROW_ITEM, 3'd0, FUNC_FIRST,   Q_ZERO, 1'b1, FRESH_FIRST},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_ZERO, 1'b1, '{1'b1, 12'd1, 1'b0, 7'd0, 13'd1}},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_MIN,  1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_MAX,  1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_UNUSED,  32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_RESTART, Q_ZERO, 1'b1, IDLE_RESULT},
            // tight value bounds: low bound stops, then the stopped state
            '{ROW_REG,  CFG_LOWER_BOUND, FUNC_FIRST, Q_M1, 1'b0, '0},
            '{ROW_REG,  CFG_UPPER_BOUND, FUNC_FIRST, Q_P1, 1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_FIRST,   Q_ZERO, 1'b1, FRESH_FIRST},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_M2,   1'b1,
              '{1'b0, 12'd0, 1'b1, 7'(1 << CAUSE_LOW), 13'd1}},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_ZERO, 1'b1, '{1'b0, 12'd0, 1'b1, 7'd0, 13'd1}},
            '{ROW_ITEM, 3'd0, FUNC_FIRST,   Q_ZERO, 1'b1, '{1'b0, 12'd0, 1'b1, 7'd0, 13'd1}},
            '{ROW_ITEM, 3'd0, FUNC_RESTART, Q_ZERO, 1'b1, IDLE_RESULT},
            '{ROW_ITEM, 3'd0, FUNC_FIRST,   Q_ZERO, 1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_P2,   1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_RESTART, Q_ZERO, 1'b0, '0},
            // finite degradation and improvement limits, short patience, warmup
            '{ROW_REG,  CFG_LOWER_BOUND,    FUNC_FIRST, Q_MIN,        1'b0, '0},
            '{ROW_REG,  CFG_UPPER_BOUND,    FUNC_FIRST, Q_MAX,        1'b0, '0},
            '{ROW_REG,  CFG_DEGRADE_LIMIT,  FUNC_FIRST, Q_ZERO,       1'b0, '0},
            '{ROW_REG,  CFG_REL_DEGRADE,    FUNC_FIRST, 32'h0001_0000, 1'b0, '0},
            '{ROW_REG,  CFG_IMPROVE_FLOOR,  FUNC_FIRST, Q_ZERO,       1'b0, '0},
            '{ROW_REG,  CFG_REL_IMPROVE,    FUNC_FIRST, Q_ZERO,       1'b0, '0},
            '{ROW_REG,  CFG_PATIENCE_STEPS, FUNC_FIRST, 32'd3,        1'b0, '0},
            '{ROW_REG,  CFG_WARMUP_STEPS,   FUNC_FIRST, 32'd2,        1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_FIRST,   Q_ZERO,    1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_P5,      1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_P4,      1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_P4_HALF, 1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_RESTART, Q_ZERO,    1'b0, '0},
            // register extremes: infinite limits, widest factors, zero patience
            '{ROW_REG,  CFG_DEGRADE_LIMIT,  FUNC_FIRST, Q_MAX,        1'b0, '0},
            '{ROW_REG,  CFG_IMPROVE_FLOOR,  FUNC_FIRST, Q_MIN,        1'b0, '0},
            '{ROW_REG,  CFG_REL_DEGRADE,    FUNC_FIRST, 32'h007F_FFFF, 1'b0, '0},
            '{ROW_REG,  CFG_REL_IMPROVE,    FUNC_FIRST, 32'h0080_0000, 1'b0, '0},
            '{ROW_REG,  CFG_PATIENCE_STEPS, FUNC_FIRST, 32'd0,        1'b0, '0},
            '{ROW_REG,  CFG_WARMUP_STEPS,   FUNC_FIRST, 32'd4096,     1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_FIRST,   Q_ZERO, 1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_M3,   1'b0, '0},
            // warmup lifted mid run: zero patience stops at once
            '{ROW_REG,  CFG_WARMUP_STEPS,   FUNC_FIRST, 32'd0,        1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_REPORT,  Q_M3,   1'b0, '0},
            '{ROW_ITEM, 3'd0, FUNC_RESTART, Q_ZERO, 1'b0, '0}
        };

        // Hold reset, then release it
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan; registers change only with the pipe empty
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (plan[r].kind == ROW_REG)
            begin
                if (r == 0 || plan[r-1].kind != ROW_REG)
                    drain();
                put_reg(plan[r].reg_idx, plan[r].value);
            end
            else
            begin
                if (r > 0 && plan[r-1].kind == ROW_REG)
                begin
                    cfg_wen <= 1'b0;
                    setting_count++;
                end
                send_item(plan[r].func, plan[r].value, plan[r].fixed, plan[r].result);
            end
        end

        // Random phases, each with its own limit registers
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            drain();
            if ($urandom_range(0, 5) == 0)
            begin
                // loose limits and a long run to use up every trial
                next_cfg[CFG_LOWER_BOUND]    = Q_MIN;
                next_cfg[CFG_UPPER_BOUND]    = Q_MAX;
                next_cfg[CFG_DEGRADE_LIMIT]  = Q_MAX;
                next_cfg[CFG_REL_DEGRADE]    = {8'h00, 1'b1, 23'($urandom)};
                next_cfg[CFG_IMPROVE_FLOOR]  = Q_MIN;
                next_cfg[CFG_REL_IMPROVE]    = {8'h00, 1'b1, 23'($urandom)};
                next_cfg[CFG_PATIENCE_STEPS] = 32'd4096;
                next_cfg[CFG_WARMUP_STEPS]   = 32'($urandom_range(0, 300));
                load_limits();
                run_sequence($urandom_range(262, 290), 1'b0);
            end
            else
            begin
                next_cfg[CFG_LOWER_BOUND]    = $urandom_range(0, 1) ? Q_MIN : rand_q();
                next_cfg[CFG_UPPER_BOUND]    = $urandom_range(0, 1) ? Q_MAX : rand_q();
                next_cfg[CFG_DEGRADE_LIMIT]  = $urandom_range(0, 2) == 0 ? Q_MAX : rand_q();
                next_cfg[CFG_REL_DEGRADE]    = rand_factor();
                next_cfg[CFG_IMPROVE_FLOOR]  = $urandom_range(0, 2) == 0 ? Q_MIN : rand_q();
                next_cfg[CFG_REL_IMPROVE]    = rand_factor();
                next_cfg[CFG_PATIENCE_STEPS] = rand_steps(30);
                next_cfg[CFG_WARMUP_STEPS]   = $urandom_range(0, 1) ? 32'd0 : rand_steps(10);
                load_limits();
                repeat ($urandom_range(1, 4))
                    run_sequence($urandom_range(4, 40), 1'b1);
            end
        end

        // Let the last results drain, then report
        drain();
        repeat (2 * PIPE_SLACK) @(posedge clk);
        $display("Sent %0d items (%0d random live), checked %0d results, %0d register sets",
                 items_sent, live_items, results_seen, setting_count);
        $display("Saw %0d stops and %0d requests after the trials ran out",
                 stop_count, exhausted_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
